/* rtl/mbce_pkg.sv */
// shared types and constants for the monochrome bitmap color expander
package mbce_pkg;

   // field widths
   localparam int ORG_W      = 11;
   localparam int DIM_W      = 12;
   localparam int COLOR_W    = 24;
   localparam int BYTE_W     = 8;
   localparam int ADDR_W     = 26;
   localparam int FW_W       = 12;
   localparam int BPP_W      = 3;
   localparam int ROW_W      = DIM_W + 1;
   localparam int CNT_W      = $clog2(BYTE_W + 1);
   localparam int MUL_W      = ADDR_W + FW_W;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [BPP_W-1:0] BPP_RESET = BPP_W'(3);

   // register index, taken from the word address bit
   typedef enum logic {
      REG_FRAME_WIDTH     = 1'b0,
      REG_BYTES_PER_PIXEL = 1'b1
   } reg_index_type;

   // item kinds
   typedef enum logic {
      ACT_BEGIN = 1'b0,
      ACT_DATA  = 1'b1
   } action_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROW_MUL,
      ST_ROW_ADD,
      ST_ROW_SCALE,
      ST_PIX
   } state_type;

endpackage

/* rtl/mono_bitmap_color_expander.sv */
// monochrome to color expansion blitter, top level
//
//  channel  | direction | handshake          | carries
//  req_     | in        | req_valid/ready    | begin fields or one bitmap byte
//  rsp_     | out       | rsp_valid/ready    | pixel address, blue, green, red, last mark
//  csr_     | in        | psel/penable       | frame_width, bytes_per_pixel
//
//  items are taken only while idle; a data byte then yields one pixel per cycle while the
//  result is not stalled (up to 8), and passes the ROW_MUL, ROW_ADD and ROW_SCALE states,
//  which share one multiplier, whenever a row base is rebuilt (row start, first byte after a begin or a write)
//  a stalled result holds the pixel sequencer and the input; once the final pixel of a
//  byte sits in the result register, the next item can be taken while it waits
//  synchronous active high reset idles the sequencer, closes the box, clears frame_width and sets bytes_per_pixel to 3
module mono_bitmap_color_expander #(
   parameter int MAX_COORD = 2048
) (
   input  logic                              clock,
   input  logic                              reset,
   // input items
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_action,
   input  logic [mbce_pkg::ORG_W-1:0]        req_origin_x,
   input  logic [mbce_pkg::ORG_W-1:0]        req_origin_y,
   input  logic [mbce_pkg::DIM_W-1:0]        req_box_width,
   input  logic [mbce_pkg::DIM_W-1:0]        req_box_height,
   input  logic [mbce_pkg::COLOR_W-1:0]      req_fore_color,
   input  logic [mbce_pkg::COLOR_W-1:0]      req_back_color,
   input  logic [mbce_pkg::BYTE_W-1:0]       req_bitmap_byte,
   // result items
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [mbce_pkg::ADDR_W-1:0]       rsp_pixel_address,
   output logic [7:0]                        rsp_blue,
   output logic [7:0]                        rsp_green,
   output logic [7:0]                        rsp_red,
   output logic                              rsp_last_pixel,
   // configuration
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [mbce_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [mbce_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [mbce_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import mbce_pkg::*;

   localparam int CLOG_MAX = $clog2(MAX_COORD + 1);
   localparam int CMP_W    = (CLOG_MAX > DIM_W) ? CLOG_MAX : DIM_W;
   localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_COORD);

   // registers
   state_type               state_ff, state_in;
   logic [FW_W-1:0]         frame_width_ff, frame_width_in;
   logic [BPP_W-1:0]        bpp_ff, bpp_in;
   logic [ORG_W-1:0]        org_col_ff, org_col_in;
   logic [ORG_W-1:0]        org_row_ff, org_row_in;
   logic [DIM_W-1:0]        box_cols_ff, box_cols_in;
   logic [DIM_W-1:0]        box_rows_ff, box_rows_in;
   logic [COLOR_W-1:0]      fg_rgb_ff, fg_rgb_in;
   logic [COLOR_W-1:0]      bg_rgb_ff, bg_rgb_in;
   logic [DIM_W-1:0]        cur_col_ff, cur_col_in;
   logic [DIM_W-1:0]        cur_row_ff, cur_row_in;
   logic                    active_ff, active_in;
   logic                    base_ok_ff, base_ok_in;
   logic [BYTE_W-1:0]       shift_ff, shift_in;
   logic [CNT_W-1:0]        bit_cnt_ff, bit_cnt_in;
   logic [ADDR_W-1:0]       lin_ff, lin_in;
   logic [ADDR_W-1:0]       pix_addr_ff, pix_addr_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]       rsp_addr_ff, rsp_addr_in;
   logic [COLOR_W-1:0]      rsp_rgb_ff, rsp_rgb_in;
   logic                    rsp_last_ff, rsp_last_in;

   // combinational
   logic                    req_fire;
   logic                    begin_fire;
   logic                    data_fire;
   logic                    cfg_write;
   logic                    pix_fire;
   logic [ADDR_W-1:0]       mul_a;
   logic [FW_W-1:0]         mul_b;
   logic [MUL_W-1:0]        mul_full;
   logic [ADDR_W-1:0]       mul_prod;
   logic [ROW_W-1:0]        row_abs;
   logic [DIM_W:0]          col_next;
   logic [DIM_W:0]          row_next;
   logic                    col_wrap;
   logic                    last_now;
   logic                    byte_done;
   logic [DIM_W-1:0]        sat_cols;
   logic [DIM_W-1:0]        sat_rows;

   // handshake decode
   assign req_fire   = req_valid && req_ready;
   assign begin_fire = req_fire && (req_action == ACT_BEGIN);
   assign data_fire  = req_fire && (req_action == ACT_DATA);
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   // box dimension saturation
   assign sat_cols = (CMP_W'(req_box_width) > MAX_CMP) ? DIM_W'(MAX_CMP) : req_box_width;
   assign sat_rows = (CMP_W'(req_box_height) > MAX_CMP) ? DIM_W'(MAX_CMP) : req_box_height;

   // pixel walk arithmetic
   assign row_abs  = ROW_W'(org_row_ff) + ROW_W'(cur_row_ff);
   assign col_next = {1'b0, cur_col_ff} + (DIM_W + 1)'(1);
   assign row_next = {1'b0, cur_row_ff} + (DIM_W + 1)'(1);
   assign col_wrap = col_next >= {1'b0, box_cols_ff};
   assign last_now = col_wrap && (row_next >= {1'b0, box_rows_ff});
   assign byte_done = last_now || (bit_cnt_ff == CNT_W'(1));

   // shared multiplier
   assign mul_full = MUL_W'(mul_a) * MUL_W'(mul_b);
   assign mul_prod = mul_full[ADDR_W-1:0];

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (data_fire && active_ff) begin
               state_in = base_ok_ff ? ST_PIX : ST_ROW_MUL;
            end
         end
         ST_ROW_MUL:   state_in = ST_ROW_ADD;
         ST_ROW_ADD:   state_in = ST_ROW_SCALE;
         ST_ROW_SCALE: state_in = ST_PIX;
         ST_PIX: begin
            if (pix_fire) begin
               if (byte_done) begin
                  state_in = ST_IDLE;
               end else if (col_wrap) begin
                  state_in = ST_ROW_MUL;
               end
            end
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      pix_fire  = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      case (state_ff)
         ST_IDLE:  req_ready = !reset;
         ST_ROW_MUL: begin
            mul_a = ADDR_W'(row_abs);
            mul_b = frame_width_ff;
         end
         ST_ROW_ADD: ;
         ST_ROW_SCALE: begin
            mul_a = lin_ff;
            mul_b = FW_W'(bpp_ff);
         end
         ST_PIX:   pix_fire = !rsp_valid_ff || rsp_ready;
         default:  ;
      endcase
   end

   // configuration registers
   always_comb begin
      frame_width_in = frame_width_ff;
      bpp_in         = bpp_ff;
      if (cfg_write) begin
         case (reg_index_type'(csr_paddr[2]))
            REG_FRAME_WIDTH:     frame_width_in = csr_pwdata[FW_W-1:0];
            REG_BYTES_PER_PIXEL: bpp_in = csr_pwdata[BPP_W-1:0];
            default:             ;
         endcase
      end
   end

   // register readback
   always_comb begin
      case (reg_index_type'(csr_paddr[2]))
         REG_FRAME_WIDTH:     csr_prdata = CSR_DATA_W'(frame_width_ff);
         REG_BYTES_PER_PIXEL: csr_prdata = CSR_DATA_W'(bpp_ff);
         default:             csr_prdata = '0;
      endcase
   end

   // box latch, walk counters and byte shifter
   always_comb begin
      org_col_in  = org_col_ff;
      org_row_in  = org_row_ff;
      box_cols_in = box_cols_ff;
      box_rows_in = box_rows_ff;
      fg_rgb_in   = fg_rgb_ff;
      bg_rgb_in   = bg_rgb_ff;
      cur_col_in  = cur_col_ff;
      cur_row_in  = cur_row_ff;
      active_in   = active_ff;
      base_ok_in  = base_ok_ff;
      shift_in    = shift_ff;
      bit_cnt_in  = bit_cnt_ff;
      if (begin_fire) begin
         org_col_in  = req_origin_x;
         org_row_in  = req_origin_y;
         box_cols_in = sat_cols;
         box_rows_in = sat_rows;
         fg_rgb_in   = req_fore_color;
         bg_rgb_in   = req_back_color;
         cur_col_in  = '0;
         cur_row_in  = '0;
         active_in   = (sat_cols != '0) && (sat_rows != '0);
         base_ok_in  = 1'b0;
      end
      if (data_fire) begin
         shift_in   = req_bitmap_byte;
         bit_cnt_in = CNT_W'(BYTE_W);
      end
      if (state_ff == ST_ROW_SCALE) begin
         base_ok_in = 1'b1;
      end
      // one pixel step
      if (pix_fire) begin
         shift_in   = {shift_ff[BYTE_W-2:0], 1'b0};
         bit_cnt_in = bit_cnt_ff - CNT_W'(1);
         if (col_wrap) begin
            cur_col_in = '0;
            cur_row_in = row_next[DIM_W-1:0];
            base_ok_in = 1'b0;
            if (last_now) begin
               active_in = 1'b0;
            end
         end else begin
            cur_col_in = col_next[DIM_W-1:0];
         end
      end
      // a new stride or pixel size invalidates the cached base address
      if (cfg_write) begin
         base_ok_in = 1'b0;
      end
   end

   // address datapath
   always_comb begin
      lin_in      = lin_ff;
      pix_addr_in = pix_addr_ff;
      case (state_ff)
         ST_ROW_MUL:   lin_in = mul_prod;
         ST_ROW_ADD:   lin_in = lin_ff + ADDR_W'(org_col_ff) + ADDR_W'(cur_col_ff);
         ST_ROW_SCALE: pix_addr_in = mul_prod;
         ST_PIX: begin
            if (pix_fire) begin
               pix_addr_in = pix_addr_ff + ADDR_W'(bpp_ff);
            end
         end
         default:      ;
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_rgb_in   = rsp_rgb_ff;
      rsp_last_in  = rsp_last_ff;
      if (pix_fire) begin
         rsp_valid_in = 1'b1;
         rsp_addr_in  = pix_addr_ff;
         rsp_rgb_in   = shift_ff[BYTE_W-1] ? fg_rgb_ff : bg_rgb_ff;
         rsp_last_in  = last_now;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         frame_width_ff <= '0;
         bpp_ff         <= BPP_RESET;
         cur_col_ff     <= '0;
         cur_row_ff     <= '0;
         active_ff      <= 1'b0;
         base_ok_ff     <= 1'b0;
         bit_cnt_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         frame_width_ff <= frame_width_in;
         bpp_ff         <= bpp_in;
         cur_col_ff     <= cur_col_in;
         cur_row_ff     <= cur_row_in;
         active_ff      <= active_in;
         base_ok_ff     <= base_ok_in;
         bit_cnt_ff     <= bit_cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload state
   always_ff @(posedge clock) begin
      org_col_ff  <= org_col_in;
      org_row_ff  <= org_row_in;
      box_cols_ff <= box_cols_in;
      box_rows_ff <= box_rows_in;
      fg_rgb_ff   <= fg_rgb_in;
      bg_rgb_ff   <= bg_rgb_in;
      shift_ff    <= shift_in;
      lin_ff      <= lin_in;
      pix_addr_ff <= pix_addr_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_rgb_ff  <= rsp_rgb_in;
      rsp_last_ff <= rsp_last_in;
   end

   // result ports
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pixel_address = rsp_addr_ff;
   assign rsp_blue          = rsp_rgb_ff[7:0];
   assign rsp_green         = rsp_rgb_ff[15:8];
   assign rsp_red           = rsp_rgb_ff[23:16];
   assign rsp_last_pixel    = rsp_last_ff;

   // pixels only step from a freshly built base address
   a_pix_base_ok: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PIX) |-> base_ok_ff)
      else $error("pixel step without a valid base address");

   // the sequencer only runs inside an open box
   a_busy_active: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (active_ff && (bit_cnt_ff != '0)))
      else $error("sequencer busy with no box open or no bits left");

   // the walk position (column and row) stays inside the box
   a_col_in_box: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> ((cur_col_ff < box_cols_ff) && (cur_row_ff < box_rows_ff)))
      else $error("walk position outside the box");

   // the final pixel closes the box and returns to idle
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      (pix_fire && last_now) |=> (!active_ff && (state_ff == ST_IDLE)))
      else $error("box still open after its final pixel");

endmodule

/* dv/mono_bitmap_color_expander_test.sv */
// self-checking bench for the monochrome bitmap color expander: directed and random items
module mono_bitmap_color_expander_test;
   import mbce_pkg::*;

   localparam int MAX_BOX        = 2048;
   localparam int SETTLE_CYCLES  = 24;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int REPORT_LIMIT   = 10;

   // one input item as seen on the req_ channel
   typedef struct {
      action_type          act;
      logic [ORG_W-1:0]    origin_x;
      logic [ORG_W-1:0]    origin_y;
      logic [DIM_W-1:0]    box_width;
      logic [DIM_W-1:0]    box_height;
      logic [COLOR_W-1:0]  fore_color;
      logic [COLOR_W-1:0]  back_color;
      logic [BYTE_W-1:0]   bitmap_byte;
   } blit_item_type;

   // one pixel write as seen on the rsp_ channel
   typedef struct {
      logic [ADDR_W-1:0]   address;
      logic [7:0]          blue;
      logic [7:0]          green;
      logic [7:0]          red;
      logic                last_pixel;
   } pixel_write_type;

   // tracks the box walk and holds the pixel writes still owed by the block
   class expander_scoreboard;
      logic [FW_W-1:0]     frame_width     = '0;
      logic [BPP_W-1:0]    bytes_per_pixel = BPP_RESET;
      logic [ORG_W-1:0]    org_col         = '0;
      logic [ORG_W-1:0]    org_row         = '0;
      logic [DIM_W-1:0]    box_cols        = '0;
      logic [DIM_W-1:0]    box_rows        = '0;
      logic [COLOR_W-1:0]  fg_rgb          = '0;
      logic [COLOR_W-1:0]  bg_rgb          = '0;
      logic [DIM_W-1:0]    cur_col         = '0;
      logic [DIM_W-1:0]    cur_row         = '0;
      logic                drawing         = 1'b0;
      pixel_write_type     expected_pixels[$];
      int unsigned         pixel_errors    = 0;

      function void set_reg(reg_index_type idx, logic [CSR_DATA_W-1:0] value);
         if (idx == REG_FRAME_WIDTH) begin
            frame_width = value[FW_W-1:0];
         end else begin
            bytes_per_pixel = value[BPP_W-1:0];
         end
      endfunction

      // oversized boxes saturate when latched
      function logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] d);
         return (d > MAX_BOX) ? DIM_W'(MAX_BOX) : d;
      endfunction

      function void absorb_item(blit_item_type it);
         pixel_write_type    px;
         logic [COLOR_W-1:0] rgb;
         logic [63:0]        col;
         logic [63:0]        row;
         logic [63:0]        offset;
         if (it.act == ACT_BEGIN) begin
            org_col  = it.origin_x;
            org_row  = it.origin_y;
            box_cols = clamp_dim(it.box_width);
            box_rows = clamp_dim(it.box_height);
            fg_rgb   = it.fore_color;
            bg_rgb   = it.back_color;
            cur_col  = '0;
            cur_row  = '0;
            drawing  = (box_cols != 0) && (box_rows != 0);
            return;
         end
         // msb first, stop once the box is covered
         for (int k = 0; k < BYTE_W && drawing; k++) begin
            rgb    = it.bitmap_byte[BYTE_W-1-k] ? fg_rgb : bg_rgb;
            col    = 64'(org_col) + 64'(cur_col);
            row    = 64'(org_row) + 64'(cur_row);
            offset = col * 64'(bytes_per_pixel)
                   + row * 64'(frame_width) * 64'(bytes_per_pixel);
            px.address    = offset[ADDR_W-1:0];
            px.blue       = rgb[7:0];
            px.green      = rgb[15:8];
            px.red        = rgb[23:16];
            px.last_pixel = 1'b0;
            cur_col++;
            if (cur_col >= box_cols) begin
               cur_col = '0;
               cur_row++;
               if (cur_row >= box_rows) begin
                  drawing       = 1'b0;
                  px.last_pixel = 1'b1;
               end
            end
            expected_pixels.push_back(px);
         end
      endfunction

      function void note_error(string msg);
         pixel_errors++;
         if (pixel_errors <= REPORT_LIMIT) begin
            $display("%s", msg);
         end
      endfunction

      function void check_pixel(pixel_write_type got);
         pixel_write_type want;
         if (expected_pixels.size() == 0) begin
            note_error($sformatf("unexpected pixel: addr %h b %h g %h r %h last %b",
                                 got.address, got.blue, got.green, got.red,
                                 got.last_pixel));
            return;
         end
         want = expected_pixels.pop_front();
         if (got.address !== want.address || got.blue !== want.blue ||
             got.green !== want.green || got.red !== want.red ||
             got.last_pixel !== want.last_pixel) begin
            note_error($sformatf({"pixel mismatch: expected addr %h b %h g %h r %h last %b,",
                                  " got addr %h b %h g %h r %h last %b"},
                                 want.address, want.blue, want.green, want.red,
                                 want.last_pixel, got.address, got.blue, got.green,
                                 got.red, got.last_pixel));
         end
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic                    req_action;
   logic [ORG_W-1:0]        req_origin_x;
   logic [ORG_W-1:0]        req_origin_y;
   logic [DIM_W-1:0]        req_box_width;
   logic [DIM_W-1:0]        req_box_height;
   logic [COLOR_W-1:0]      req_fore_color;
   logic [COLOR_W-1:0]      req_back_color;
   logic [BYTE_W-1:0]       req_bitmap_byte;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [ADDR_W-1:0]       rsp_pixel_address;
   logic [7:0]              rsp_blue;
   logic [7:0]              rsp_green;
   logic [7:0]              rsp_red;
   logic                    rsp_last_pixel;
   logic                    csr_psel;
   logic                    csr_penable;
   logic                    csr_pwrite;
   logic [CSR_ADDR_W-1:0]   csr_paddr;
   logic [CSR_DATA_W-1:0]   csr_pwdata;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   expander_scoreboard      sb = new;
   logic                    calm = 1'b0;
   logic                    hold_req = 1'b0;
   logic                    hold_seen = 1'b0;
   int unsigned             hold_left = 0;
   int unsigned             idle_cycles = 0;
   int unsigned             random_items;

   mono_bitmap_color_expander DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_origin_x      (req_origin_x),
      .req_origin_y      (req_origin_y),
      .req_box_width     (req_box_width),
      .req_box_height    (req_box_height),
      .req_fore_color    (req_fore_color),
      .req_back_color    (req_back_color),
      .req_bitmap_byte   (req_bitmap_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_blue          (rsp_blue),
      .rsp_green         (rsp_green),
      .rsp_red           (rsp_red),
      .rsp_last_pixel    (rsp_last_pixel),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   // clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // result side: check accepted pixels, random stalls and one long hold-off
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_pixel(pixel_write_type'{rsp_pixel_address, rsp_blue, rsp_green, rsp_red,
                                          rsp_last_pixel});
      end
      if (hold_req != hold_seen) begin
         hold_seen = hold_req;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(99) >= 9);
      end
   end

   // watchdog on cycles with no traffic at all
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // offer one item, hold it until taken, then maybe idle a little
   task automatic send_item(input blit_item_type it);
      req_valid       <= 1'b1;
      req_action      <= it.act;
      req_origin_x    <= it.origin_x;
      req_origin_y    <= it.origin_y;
      req_box_width   <= it.box_width;
      req_box_height  <= it.box_height;
      req_fore_color  <= it.fore_color;
      req_back_color  <= it.back_color;
      req_bitmap_byte <= it.bitmap_byte;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.absorb_item(it);
      if (!calm && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   // begin item; the byte field is don't-care and gets noise
   task automatic send_begin(input logic [ORG_W-1:0] x, input logic [ORG_W-1:0] y,
                             input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                             input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg);
      blit_item_type it;
      it = '{ACT_BEGIN, x, y, w, h, fg, bg, BYTE_W'($urandom)};
      send_item(it);
   endtask

   // data item; the begin fields are don't-care and get noise
   task automatic send_byte(input logic [BYTE_W-1:0] b);
      blit_item_type it;
      it = '{ACT_DATA, ORG_W'($urandom), ORG_W'($urandom), DIM_W'($urandom),
             DIM_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom), b};
      send_item(it);
   endtask

   // register write: setup phase then access phase
   task automatic write_reg(input reg_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(idx) << 2;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.set_reg(idx, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // stop offering, wait for every owed pixel, then let the sequencer go quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // mostly small boxes, now and then a large one
   function automatic logic [DIM_W-1:0] pick_dim();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 80) return DIM_W'($urandom_range(1, 10));
      if (r < 93) return DIM_W'($urandom_range(11, 40));
      return DIM_W'($urandom_range(41, 4095));
   endfunction

   // one well-formed box: begin then enough bytes, sometimes short or with spare bytes
   task automatic send_box();
      logic [DIM_W-1:0] w;
      logic [DIM_W-1:0] h;
      int unsigned      nbytes;
      w = pick_dim();
      h = pick_dim();
      send_begin(ORG_W'($urandom), ORG_W'($urandom), w, h, COLOR_W'($urandom),
                 COLOR_W'($urandom));
      nbytes = (int'(w) * int'(h) + 7) / 8;
      if (nbytes > 40) begin
         nbytes = $urandom_range(4, 40);
      end else if ($urandom_range(9) == 0) begin
         nbytes += $urandom_range(1, 2);
      end else if ($urandom_range(9) == 0 && nbytes > 1) begin
         nbytes--;
      end
      repeat (nbytes) send_byte(BYTE_W'($urandom));
      random_items += 1 + nbytes;
   endtask

   // stray bytes, empty boxes and abandoned boxes
   task automatic send_noise();
      case ($urandom_range(2))
         0: begin
            send_byte(BYTE_W'($urandom));
            random_items += 1;
         end
         1: begin
            if ($urandom_range(1) == 0) begin
               send_begin(ORG_W'($urandom), ORG_W'($urandom), '0, DIM_W'($urandom),
                          COLOR_W'($urandom), COLOR_W'($urandom));
            end else begin
               send_begin(ORG_W'($urandom), ORG_W'($urandom), DIM_W'($urandom), '0,
                          COLOR_W'($urandom), COLOR_W'($urandom));
            end
            send_byte(BYTE_W'($urandom));
            random_items += 2;
         end
         default: begin
            send_begin(ORG_W'($urandom), ORG_W'($urandom), pick_dim(), pick_dim(),
                       COLOR_W'($urandom), COLOR_W'($urandom));
            send_byte(BYTE_W'($urandom));
            random_items += 2;
         end
      endcase
   endtask

   // one register setting followed by random traffic
   task automatic run_phase(input logic [CSR_DATA_W-1:0] fw, input logic [CSR_DATA_W-1:0] bpp,
                            input int unsigned quota, input bit stress);
      settle();
      write_reg(REG_FRAME_WIDTH, fw);
      write_reg(REG_BYTES_PER_PIXEL, bpp);
      if (stress) begin
         hold_req <= ~hold_req;
      end
      random_items = 0;
      while (random_items < quota) begin
         if ($urandom_range(99) < 85) begin
            send_box();
         end else begin
            send_noise();
         end
      end
   endtask

   // main sequence
   initial begin
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_action      <= ACT_BEGIN;
      req_origin_x    <= '0;
      req_origin_y    <= '0;
      req_box_width   <= '0;
      req_box_height  <= '0;
      req_fore_color  <= '0;
      req_back_color  <= '0;
      req_bitmap_byte <= '0;
      csr_psel        <= 1'b0;
      csr_penable     <= 1'b0;
      csr_pwrite      <= 1'b0;
      csr_paddr       <= '0;
      csr_pwdata      <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      write_reg(REG_FRAME_WIDTH, 800);
      write_reg(REG_BYTES_PER_PIXEL, 3);

      // data with no begin since reset
      send_byte(8'hFF);
      // 3x2 box: second row wraps inside the byte, spare bits and later byte dropped
      send_begin(0, 0, 3, 2, 24'hFFFFFF, 24'h000000);
      send_byte(8'hA5);
      send_byte(8'h5A);
      // empty boxes leave the block idle
      send_begin(5, 7, 0, 4, 24'h00FF00, 24'hFF0000);
      send_byte(8'hFF);
      send_begin(5, 7, 4, 0, 24'h00FF00, 24'hFF0000);
      send_byte(8'h00);
      // single row at the far corner
      send_begin(11'h7FF, 11'h7FF, 9, 1, 24'h123456, 24'hABCDEF);
      send_byte(8'hFF);
      send_byte(8'h00);
      // rows that end mid byte
      send_begin(10, 20, 5, 3, 24'hAAAAAA, 24'h555555);
      send_byte(8'hF0);
      send_byte(8'h0F);
      // largest dims, abandoned early
      send_begin(0, 0, 12'hFFF, 12'hFFF, 24'hFFFFFF, 24'h000000);
      send_byte(8'h80);
      send_byte(8'h7F);
      // one pixel box
      send_begin(1, 1, 1, 1, 24'h0000FF, 24'hFFFF00);
      send_byte(8'h80);
      send_byte(8'hFF);

      // zero pixel size: every offset is zero
      run_phase(0, 0, 35, 1'b0);

      // largest stride and pixel size, then a tall thin box that wraps the offset
      run_phase(4095, 7, 35, 1'b0);
      send_begin(11'h7FF, 11'h7FF, 1, 12'hFFF, COLOR_W'($urandom), COLOR_W'($urandom));
      repeat (48) send_byte(BYTE_W'($urandom));

      // no idling on either side
      calm <= 1'b1;
      run_phase(2048, 4, 35, 1'b0);
      calm <= 1'b0;

      // receiver holds off while items keep coming
      run_phase(CSR_DATA_W'($urandom_range(4095)), 3, 50, 1'b1);

      run_phase(CSR_DATA_W'($urandom_range(4095)), CSR_DATA_W'($urandom_range(7)), 55,
                1'b0);

      settle();
      if (sb.pixel_errors == 0 && sb.expected_pixels.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/mbce_pkg.sv
rtl/mono_bitmap_color_expander.sv
dv/mono_bitmap_color_expander_test.sv
